// ----- sv/scf_pkg.sv -----
// ----------------------------------------------------------------------------
// scf_pkg
// Shared constants, types and tap helpers of the separable convolution filter.
// ----------------------------------------------------------------------------
package scf_pkg;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAX_TAPS  = 7;

   localparam int PIX_W    = 8;
   localparam int TAP_W    = 16;
   localparam int INTER_W  = 20;
   localparam int OUT_W    = 16;
   localparam int HACC_W   = 28;
   localparam int VACC_W   = 40;
   localparam int ROW_W    = 13;
   localparam int HALF_W   = 2;
   localparam int TIDX_W   = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_HALF  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PASS_MODE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TAPS_LOW     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TAPS_HIGH    = 3'd5;

   localparam logic [1:0] MODE_BOTH  = 2'd0;
   localparam logic [1:0] MODE_HORIZ = 2'd1;
   localparam logic [1:0] MODE_VERT  = 2'd2;

   localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd512;
   localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd512;
   localparam logic [1:0]  RST_KERNEL_HALF  = 2'd1;

   localparam logic signed [TAP_W-1:0] IDENT_TAP = 16'sh4000;

   typedef struct packed {
      logic last_col;
      logic last_row;
      logic in_image;
      logic do_calc;
      logic do_emit;
   } scan_flags_type;

   function automatic logic signed [TAP_W-1:0] tap_of(
      input logic [63:0] lo,
      input logic [47:0] hi,
      input logic [TIDX_W-1:0] t
   );
      logic signed [TAP_W-1:0] v;
      case (t)
         3'd0: v = lo[15:0];
         3'd1: v = lo[31:16];
         3'd2: v = lo[47:32];
         3'd3: v = lo[63:48];
         3'd4: v = hi[15:0];
         3'd5: v = hi[31:16];
         3'd6: v = hi[47:32];
         default: v = '0;
      endcase
      return v;
   endfunction

   // effective coefficient of one pass: programmed taps or identity
   function automatic logic signed [TAP_W-1:0] coef(
      input logic use_pass,
      input logic [63:0] lo,
      input logic [47:0] hi,
      input logic [TIDX_W-1:0] t,
      input logic [HALF_W-1:0] h
   );
      logic signed [TAP_W-1:0] v;
      if (use_pass) begin
         v = (t <= {h, 1'b0}) ? tap_of(lo, hi, t) : '0;
      end else begin
         v = (t == {1'b0, h}) ? IDENT_TAP : '0;
      end
      return v;
   endfunction

endpackage

// ----- sv/scf_ram.sv -----
// ----------------------------------------------------------------------------
// scf_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/scf_scan.sv -----
// ----------------------------------------------------------------------------
// scf_scan
// Raster position counters: column, row and line store slot of each item.
// ----------------------------------------------------------------------------
module scf_scan
   import scf_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_TAPS  = DEF_MAX_TAPS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic [$clog2(MAX_WIDTH+(MAX_TAPS-1)/2)-1:0] width_eff,
   input  logic [11:0]                             height_eff,
   input  logic [HALF_W-1:0]                       half_eff,
   output logic [$clog2(MAX_WIDTH+(MAX_TAPS-1)/2)-1:0] col,
   output logic [ROW_W-1:0]                        row,
   output logic [$clog2(MAX_TAPS-1)-1:0]           slot,
   output scan_flags_type                          flags
);

   localparam int MAX_HALF = (MAX_TAPS - 1) / 2;
   localparam int CW       = $clog2(MAX_WIDTH + MAX_HALF);
   localparam int SLOTS    = MAX_TAPS - 1;
   localparam int SW       = $clog2(SLOTS);

   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [CW-1:0]    end_col;
   logic [ROW_W-1:0] end_row;

   assign end_col = width_eff + CW'(half_eff) - CW'(1);
   assign end_row = ROW_W'(height_eff) + ROW_W'(half_eff) - ROW_W'(1);

   always_comb begin
      flags.last_col = col_ff >= end_col;
      flags.last_row = row_ff >= end_row;
      flags.in_image = (col_ff < width_eff) && (row_ff < ROW_W'(height_eff));
      flags.do_calc  = col_ff >= CW'(half_eff);
      flags.do_emit  = row_ff >= ROW_W'(half_eff);
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (advance) begin
         if (flags.last_col) begin
            col_in = '0;
            if (flags.last_row) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = row_ff + ROW_W'(1);
               slot_in = (slot_ff == SW'(SLOTS - 1)) ? '0 : slot_ff + SW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   assign col  = col_ff;
   assign row  = row_ff;
   assign slot = slot_ff;

endmodule

// ----- sv/separable_convolution_filter_top.sv -----
// ----------------------------------------------------------------------------
// separable_convolution_filter_top
// Separable 2-D convolution of an 8-bit raster stream, odd kernel of up to
// seven Q1.14 taps, row pass into a line store and column pass out of it.
//
//   channel   ports                               direction
//   req       req_valid, req_stall, req_pixel_value   in
//   rsp       rsp_valid, rsp_stall, rsp_filtered_value, rsp_frame_end   out
//   csr       csr_write_enable, csr_index, csr_write_data   in
//
// an item before column h is accepted without a stall; any other item runs
// one row multiply-accumulate per tap, then one column multiply-accumulate
// per tap over the line store word read for that column
// synchronous active-high reset, line store contents undefined after reset
// a result waiting on rsp_stall holds the next item only at its last step
// ----------------------------------------------------------------------------
module separable_convolution_filter_top
   import scf_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_TAPS  = DEF_MAX_TAPS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [PIX_W-1:0]             req_pixel_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [OUT_W-1:0]      rsp_filtered_value,
   output logic                         rsp_frame_end,
   input  logic                         csr_write_enable,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data
);

   localparam int MAX_HALF = (MAX_TAPS - 1) / 2;
   localparam int CW       = $clog2(MAX_WIDTH + MAX_HALF);
   localparam int SLOTS    = MAX_TAPS - 1;
   localparam int SW       = $clog2(SLOTS);
   localparam int AW       = $clog2(MAX_WIDTH);
   localparam int WIN_W    = $clog2(MAX_TAPS);
   localparam int WORD_W   = SLOTS * INTER_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_HMAC  = 3'd1;
   localparam logic [2:0] ST_HFIN  = 3'd2;
   localparam logic [2:0] ST_VINIT = 3'd3;
   localparam logic [2:0] ST_VMAC  = 3'd4;
   localparam logic [2:0] ST_VFIN  = 3'd5;

   logic [10:0] width_ff;
   logic [11:0] height_ff;
   logic [1:0]  half_ff;
   logic [1:0]  mode_ff;
   logic [63:0] taps_lo_ff;
   logic [47:0] taps_hi_ff;

   logic [12:0]        width_ext;
   logic [CW-1:0]      width_eff;
   logic [11:0]        height_eff;
   logic [HALF_W-1:0]  half_eff;
   logic               horiz, vert;

   logic [CW-1:0]      col;
   logic [ROW_W-1:0]   row;
   logic [SW-1:0]      slot;
   scan_flags_type     flags;
   logic               accept;

   logic [2:0]            state_ff, state_in;
   logic [TIDX_W-1:0]     tap_ff, tap_in;
   logic [PIX_W-1:0]      win_ff [MAX_TAPS];
   scan_flags_type        flags_ff;
   logic [ROW_W-1:0]      row_ff;
   logic [SW-1:0]         slot_ff;
   logic [AW-1:0]         x_ff;
   logic [CW-1:0]         x_diff;
   logic [AW-1:0]         x_addr;
   logic signed [HACC_W-1:0]  hacc_ff, hacc_in;
   logic signed [VACC_W-1:0]  vacc_ff, vacc_in;
   logic signed [INTER_W-1:0] inter_ff;
   logic signed [INTER_W-1:0] inter_in;
   logic [WORD_W-1:0]     word_ff;
   logic [WORD_W-1:0]     ram_rd_data;
   logic [WORD_W-1:0]     wb_word;
   logic                  ram_wr;

   logic [TIDX_W-1:0]     two_h;
   logic [WIN_W-1:0]      win_idx;
   logic signed [PIX_W:0] win_pix;
   logic signed [TAP_W-1:0] h_coef, v_coef, v_center;
   logic signed [PIX_W+TAP_W:0] hprod;
   logic signed [HACC_W:0]  hround, hshift;
   logic [TIDX_W-1:0]     row_back;
   logic [SW:0]           slot_sum;
   logic [SW-1:0]         rd_slot;
   logic signed [INTER_W-1:0] slot_val;
   logic signed [INTER_W+TAP_W-1:0] vprod;
   logic signed [VACC_W:0]  vround, vshift;
   logic signed [OUT_W-1:0] res;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_value_ff;
   logic                  rsp_end_ff;
   logic                  rsp_load;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= RST_IMAGE_WIDTH;
         height_ff  <= RST_IMAGE_HEIGHT;
         half_ff    <= RST_KERNEL_HALF;
         mode_ff    <= MODE_BOTH;
         taps_lo_ff <= '0;
         taps_hi_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_ff   <= csr_write_data[10:0];
            REG_IMAGE_HEIGHT: height_ff  <= csr_write_data[11:0];
            REG_KERNEL_HALF:  half_ff    <= csr_write_data[1:0];
            REG_PASS_MODE:    mode_ff    <= csr_write_data[1:0];
            REG_TAPS_LOW:     taps_lo_ff <= csr_write_data;
            REG_TAPS_HIGH:    taps_hi_ff <= csr_write_data[47:0];
            default: ;
         endcase
      end
   end

   assign width_ext  = {2'b00, width_ff};
   assign width_eff  = (width_ff == '0) ? CW'(1) :
                       (width_ext > 13'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_ext);
   assign height_eff = (height_ff == '0) ? 12'd1 : height_ff;
   assign half_eff   = (half_ff > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_ff;
   assign horiz      = mode_ff != MODE_VERT;
   assign vert       = mode_ff != MODE_HORIZ;

   scf_scan #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_TAPS  (MAX_TAPS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .half_eff   (half_eff),
      .col        (col),
      .row        (row),
      .slot       (slot),
      .flags      (flags)
   );

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = state_ff != ST_IDLE;

   // column address of the line store
   assign x_diff = col - CW'(half_eff);
   assign x_addr = (x_diff >= CW'(MAX_WIDTH)) ? AW'(x_diff - CW'(MAX_WIDTH)) : AW'(x_diff);

   scf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (x_ff),
      .wr_data (wb_word),
      .rd_en   (accept && flags.do_calc),
      .rd_addr (x_addr),
      .rd_data (ram_rd_data)
   );

   // row pass
   assign two_h   = TIDX_W'({half_eff, 1'b0});
   assign win_idx = WIN_W'(two_h - tap_ff);
   assign win_pix = $signed({1'b0, win_ff[win_idx]});
   assign h_coef  = coef(horiz, taps_lo_ff, taps_hi_ff, tap_ff, half_eff);
   assign hprod   = win_pix * h_coef;
   assign hround  = (HACC_W+1)'(hacc_ff) + (HACC_W+1)'(512);
   assign hshift  = hround >>> 10;

   always_comb begin
      if ((&hshift[HACC_W:INTER_W-1]) || !(|hshift[HACC_W:INTER_W-1])) begin
         inter_in = hshift[INTER_W-1:0];
      end else begin
         inter_in = hshift[HACC_W] ? {1'b1, {(INTER_W-1){1'b0}}} : {1'b0, {(INTER_W-1){1'b1}}};
      end
   end

   // column pass
   assign v_center = coef(vert, taps_lo_ff, taps_hi_ff, two_h, half_eff);
   assign v_coef   = coef(vert, taps_lo_ff, taps_hi_ff, tap_ff, half_eff);
   assign row_back = two_h - tap_ff;
   assign slot_sum = (SW+1)'(slot_ff) + (SW+1)'(SLOTS) - (SW+1)'(row_back);
   assign rd_slot  = (slot_sum >= (SW+1)'(SLOTS)) ? SW'(slot_sum - (SW+1)'(SLOTS))
                                                  : SW'(slot_sum);
   assign slot_val = word_ff[rd_slot*INTER_W +: INTER_W];
   assign vprod    = slot_val * v_coef;
   assign vround   = (VACC_W+1)'(vacc_ff) + (VACC_W+1)'(131072);
   assign vshift   = vround >>> 18;

   always_comb begin
      if ((&vshift[VACC_W:OUT_W-1]) || !(|vshift[VACC_W:OUT_W-1])) begin
         res = vshift[OUT_W-1:0];
      end else begin
         res = vshift[VACC_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      end
   end

   always_comb begin
      wb_word = word_ff;
      for (int s = 0; s < SLOTS; s++) begin
         if (slot_ff == SW'(s)) begin
            wb_word[s*INTER_W +: INTER_W] = inter_ff;
         end
      end
   end

   assign ram_wr   = state_ff == ST_VINIT;
   assign rsp_load = (state_ff == ST_VFIN) && flags_ff.do_emit &&
                     (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      hacc_in  = hacc_ff;
      vacc_in  = vacc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && flags.do_calc) begin
               state_in = ST_HMAC;
               tap_in   = '0;
               hacc_in  = '0;
            end
         end
         ST_HMAC: begin
            hacc_in = hacc_ff + HACC_W'(hprod);
            if (tap_ff == two_h) begin
               state_in = ST_HFIN;
            end else begin
               tap_in = tap_ff + TIDX_W'(1);
            end
         end
         ST_HFIN: begin
            state_in = ST_VINIT;
         end
         ST_VINIT: begin
            vacc_in = VACC_W'(inter_ff * v_center);
            tap_in  = '0;
            state_in = (half_eff == '0) ? ST_VFIN : ST_VMAC;
         end
         ST_VMAC: begin
            if (row_ff >= ROW_W'(row_back)) begin
               vacc_in = vacc_ff + VACC_W'(vprod);
            end
            if (tap_ff == two_h - TIDX_W'(1)) begin
               state_in = ST_VFIN;
            end else begin
               tap_in = tap_ff + TIDX_W'(1);
            end
         end
         ST_VFIN: begin
            if (!flags_ff.do_emit || rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_TAPS; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            win_ff[0] <= flags.in_image ? req_pixel_value : '0;
            for (int i = 1; i < MAX_TAPS; i++) begin
               win_ff[i] <= (col == '0) ? '0 : win_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      tap_ff  <= tap_in;
      hacc_ff <= hacc_in;
      vacc_ff <= vacc_in;
      if (accept) begin
         flags_ff <= flags;
         row_ff   <= row;
         slot_ff  <= slot;
         x_ff     <= x_addr;
      end
      if (state_ff == ST_HFIN) begin
         inter_ff <= inter_in;
         word_ff  <= ram_rd_data;
      end
      if (rsp_load) begin
         rsp_value_ff <= res;
         rsp_end_ff   <= flags_ff.last_col && flags_ff.last_row;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_frame_end      = rsp_end_ff;

`ifndef SYNTHESIS
   a_tap_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HMAC |-> tap_ff <= two_h)
      else $error("row tap index past kernel end");

   a_skip_stays_idle: assert property (@(posedge clock) disable iff (reset)
      accept && !flags.do_calc |=> state_ff == ST_IDLE)
      else $error("item left of kernel start entered the datapath");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_VFIN)
      else $error("item presented without a finished column pass");
`endif

endmodule
